// ===== rtl/core/pirb_pkg.sv =====
// ---------------------------------------------------------------------------
// pirb_pkg
// Shared types and constants for the phase indexed record buffer.
// ---------------------------------------------------------------------------
package pirb_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PHASE_W   = 16;
  localparam int POS_OUT_W = 10;
  localparam int CFG_W     = 8;
  localparam int REG_IDX_W = 1;
  localparam int DIV_W     = 8;

  localparam logic [REG_IDX_W-1:0] REG_WRITE_ENABLE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_DIVIDE       = 1'd1;

  localparam logic [DIV_W-1:0] DIV_MIN = 8'd1;
  localparam logic [DIV_W-1:0] DIV_MAX = 8'd128;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_BAKE    = 2'd2,
    OP_REBUILD = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_TICK,
    ST_CLEAR,
    ST_BAKE,
    ST_DIV,
    ST_SEG_RD,
    ST_SEG_WR
  } state_t;

endpackage

// ===== rtl/core/pirb_divider.sv =====
// ---------------------------------------------------------------------------
// pirb_divider
// Bit-serial restoring divider: DEPTH divided by an 8-bit divisor, one
// quotient bit per cycle, most significant bit first.
// ---------------------------------------------------------------------------
module pirb_divider import pirb_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [DIV_W-1:0]                  divisor,
  output logic                              done,
  output logic [$clog2(DEPTH+1)-1:0]        quotient,
  output logic                              inexact
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int BW = $clog2(CW);
  localparam logic [CW-1:0] DIVIDEND = CW'(DEPTH);

  logic             busy;
  logic [BW-1:0]    bidx;
  logic [DIV_W-1:0] rem;
  logic [DIV_W:0]   trial;
  logic             fits;
  logic [DIV_W-1:0] rem_next;

  assign trial    = {rem, DIVIDEND[bidx]};
  assign fits     = trial >= {1'b0, divisor};
  assign rem_next = fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
  assign inexact  = rem != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bidx == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bidx     <= BW'(CW - 1);
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      bidx     <= bidx - 1'b1;
      rem      <= rem_next;
      quotient <= {quotient[CW-2:0], fits};
    end
  end

  // quotient bits shift in once per cycle; the last one lands with done
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a finished run");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < divisor)
    else $error("divider remainder not below divisor");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && rem == '0)
    else $error("divider did not load on start");

endmodule

// ===== rtl/core/phase_indexed_record_buffer.sv =====
// ---------------------------------------------------------------------------
// phase_indexed_record_buffer
// Phase addressed recording store with a stepped overlay store. Ticks read both
// stores at the playhead, may write the recording; bulk ops sweep them.
// ---------------------------------------------------------------------------
//  channel  | direction | beat contents
//  s_t*     | in        | tuser: op; tdata: phase, sample_in, write_req
//  m_t*     | out       | tdata: recorded_value, overlay_value, position
//  cfg_*    | in        | write enable, register index, write data
//
//  Tick: accept, then a synchronous memory read.
//  Clear: a sweep zeroing the recording; bake: read overlay, write recording
//  one entry behind. Rebuild: division, then per segment start one read
//  of the start value plus an overlay write per covered position, and a
//  closing read state.
//  After reset a clearing pass zeroes both stores; s_tready stays low
//  meanwhile. A result waiting in the output register does not block
//  acceptance, but the next tick then holds in its read state, with
//  s_tready low, until that result is taken.
// ---------------------------------------------------------------------------
module phase_indexed_record_buffer import pirb_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  // stream in
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,   // phase[15:0], sample_in[31:16], write_req[32]
  input  logic [1:0]           s_tuser,   // op[1:0]
  // stream out
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [47:0]          m_tdata,   // recorded_value[15:0], overlay_value[31:16],
                                          // position[41:32]
  // configuration
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = PHASE_W + CW;
  localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);
  localparam logic [CW-1:0] LAST_CW  = CW'(DEPTH - 1);

  state_t state, state_next;

  // configuration registers
  logic             write_enable;
  logic [DIV_W-1:0] divide;
  logic [DIV_W-1:0] divide_eff;

  // input beat fields
  op_t                 op_in;
  logic [PHASE_W-1:0]  phase_in;
  logic [SAMPLE_W-1:0] sample_in;
  logic                write_req;
  logic                accept;
  logic [PW-1:0]       prod;
  logic [AW-1:0]       pos_in;

  // tick registers
  logic [AW-1:0]       pos_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                wrote_r;

  // sweep and segment counters
  logic [CW-1:0]   cnt;
  logic [AW-1:0]   cnt_prev;
  logic [CW:0]     seg_s;
  logic [CW-1:0]   seg_j;
  logic [CW-1:0]   seg_q;
  logic [CW-1:0]   seg_n;
  logic [CW:0]     seg_end;
  logic [CW:0]     j_inc;
  logic            seg_last;

  // divider
  logic          div_start;
  logic          div_done;
  logic [CW-1:0] div_quo;
  logic          div_inexact;

  // memories
  logic [SAMPLE_W-1:0] rec_mem [DEPTH];
  logic [SAMPLE_W-1:0] ovl_mem [DEPTH];
  logic                rec_we, ovl_we;
  logic [AW-1:0]       rec_wa, ovl_wa, rec_ra, ovl_ra;
  logic [SAMPLE_W-1:0] rec_wd, ovl_wd, rec_rd, ovl_rd;

  logic out_load;

  assign op_in     = op_t'(s_tuser[1:0]);
  assign phase_in  = s_tdata[15:0];
  assign sample_in = s_tdata[31:16];
  assign write_req = s_tdata[32];
  assign s_tready  = state == ST_IDLE;
  assign accept    = s_tvalid && s_tready;

  assign prod   = PW'(phase_in) * PW'(DEPTH);
  assign pos_in = prod[PHASE_W +: AW];

  assign divide_eff = (divide == '0) ? DIV_MIN : ((divide > DIV_MAX) ? DIV_MAX : divide);

  assign cnt_prev = AW'(cnt - 1'b1);
  assign seg_end  = seg_s + {1'b0, seg_n};
  assign j_inc    = {1'b0, seg_j} + 1'b1;
  assign seg_last = (j_inc >= seg_end) || (j_inc >= {1'b0, DEPTH_CW});

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      write_enable <= 1'b1;
      divide       <= DIV_MIN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WRITE_ENABLE: write_enable <= cfg_data[0];
        REG_DIVIDE:       divide       <= cfg_data;
        default:          ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:  if (cnt == LAST_CW) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (op_in)
            OP_TICK:    state_next = ST_TICK;
            OP_CLEAR:   state_next = ST_CLEAR;
            OP_BAKE:    state_next = ST_BAKE;
            OP_REBUILD: state_next = ST_DIV;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_TICK:   if (out_load) state_next = ST_IDLE;
      ST_CLEAR:  if (cnt == LAST_CW) state_next = ST_IDLE;
      ST_BAKE:   if (cnt == DEPTH_CW) state_next = ST_IDLE;
      ST_DIV:    if (div_done) state_next = ST_SEG_RD;
      ST_SEG_RD: state_next = (seg_s >= {1'b0, LAST_CW}) ? ST_IDLE : ST_SEG_WR;
      ST_SEG_WR: if (seg_last) state_next = ST_SEG_RD;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory controls and strobes
  always_comb begin
    rec_we    = 1'b0;
    rec_wa    = pos_in;
    rec_wd    = sample_in;
    rec_ra    = pos_r;
    ovl_we    = 1'b0;
    ovl_wa    = cnt[AW-1:0];
    ovl_wd    = '0;
    ovl_ra    = pos_r;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_INIT: begin
        rec_we = 1'b1;
        rec_wa = cnt[AW-1:0];
        rec_wd = '0;
        ovl_we = 1'b1;
      end
      ST_IDLE: begin
        rec_ra = pos_in;
        ovl_ra = pos_in;
        if (accept && op_in == OP_TICK && write_enable && write_req) rec_we = 1'b1;
        if (accept && op_in == OP_REBUILD) div_start = 1'b1;
      end
      ST_TICK: out_load = !m_tvalid || m_tready;
      ST_CLEAR: begin
        rec_we = 1'b1;
        rec_wa = cnt[AW-1:0];
        rec_wd = '0;
      end
      ST_BAKE: begin
        // read overlay at cnt, write recording one entry behind
        ovl_ra = cnt[AW-1:0];
        rec_we = cnt != '0;
        rec_wa = cnt_prev;
        rec_wd = ovl_rd;
      end
      ST_SEG_RD: rec_ra = seg_s[AW-1:0];
      ST_SEG_WR: begin
        // hold the read address so the start value stays on rec_rd
        rec_ra = seg_s[AW-1:0];
        ovl_we = 1'b1;
        ovl_wa = seg_j[AW-1:0];
        ovl_wd = rec_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_rd <= rec_mem[rec_ra];
  end

  always_ff @(posedge clk) begin
    if (ovl_we) ovl_mem[ovl_wa] <= ovl_wd;
    ovl_rd <= ovl_mem[ovl_ra];
  end

  pirb_divider #(
    .DEPTH (DEPTH)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (divide_eff),
    .done     (div_done),
    .quotient (div_quo),
    .inexact  (div_inexact)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: cnt <= '0;
        ST_INIT, ST_CLEAR, ST_BAKE: cnt <= cnt + 1'b1;
        default: ;
      endcase
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept && op_in == OP_TICK) begin
      pos_r    <= pos_in;
      sample_r <= sample_in;
      wrote_r  <= write_enable && write_req;
    end
    if (div_done) begin
      seg_q <= (div_quo == '0) ? CW'(1) : div_quo;
      seg_n <= div_quo + CW'(div_inexact);
      seg_s <= '0;
    end
    if (state == ST_SEG_RD) seg_j <= seg_s[CW-1:0];
    if (state == ST_SEG_WR) begin
      if (seg_last) begin
        seg_s <= seg_s + {1'b0, seg_q};
      end else begin
        seg_j <= seg_j + 1'b1;
      end
    end
    if (out_load) begin
      // forward the freshly written sample over the pre-write read
      m_tdata[15:0]  <= wrote_r ? sample_r : rec_rd;
      m_tdata[31:16] <= ovl_rd;
      m_tdata[41:32] <= POS_OUT_W'(pos_r);
      m_tdata[47:42] <= '0;
    end
  end

  a_tick_to_read: assert property (@(posedge clk) disable iff (rst)
    (accept && op_in == OP_TICK) |=> state == ST_TICK)
    else $error("tick accept did not enter the read state");

  a_valid_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_TICK))
    else $error("result raised outside a tick");

  a_single_store_write: assert property (@(posedge clk) disable iff (rst)
    (rec_we && ovl_we) |-> state == ST_INIT)
    else $error("both stores written outside the clearing pass");

  a_seg_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEG_WR) |-> seg_j < DEPTH_CW && {1'b0, seg_j} < seg_end)
    else $error("overlay segment write out of range");

endmodule

// ===== bench/tb_phase_indexed_record_buffer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_phase_indexed_record_buffer
// Drives ticks and bulk ops (clear, bake, rebuild) into the record buffer
// under several write gate and divide settings, predicts both stores in the
// bench, and checks every result beat against the oldest predicted read.
// ---------------------------------------------------------------------------
module tb_phase_indexed_record_buffer;
  import pirb_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int BULK_DRAIN  = 2000;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  rec;
    logic [SAMPLE_W-1:0]  ovl;
    logic [POS_OUT_W-1:0] pos;
  } playhead_read_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [39:0]          s_tdata;   // phase[15:0], sample_in[31:16], write_req[32]
  logic [1:0]           s_tuser;   // op[1:0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [47:0]          m_tdata;   // recorded_value[15:0], overlay_value[31:16],
                                   // position[41:32]
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // bench copy of the block state
  logic [SAMPLE_W-1:0] rec_mem [DEPTH];
  logic [SAMPLE_W-1:0] ovl_mem [DEPTH];
  logic                wr_gate;
  logic [DIV_W-1:0]    div_reg;

  playhead_read_t readout_q[$];
  playhead_read_t want;
  int             mismatches = 0;
  int             cycle_cnt = 0;
  int             sink_hold = 0;
  bit             src_idle_on = 1'b1;
  bit             sink_idle_on = 1'b1;

  phase_indexed_record_buffer #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: after each taken beat, if sink_idle_on, hold tready low for a random stall, which may be empty
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_hold = 0;
    end else if (m_tready) begin
      if (m_tvalid && sink_idle_on) begin
        sink_hold = $urandom_range(0, 7);
        if (sink_hold != 0) begin
          m_tready <= 1'b0;
          sink_hold = sink_hold - 1;
        end
      end
    end else if (sink_hold > 0) begin
      sink_hold = sink_hold - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (readout_q.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_tdata);
        mismatches++;
      end else begin
        want = readout_q.pop_front();
        if (m_tdata[15:0] !== want.rec) begin
          $error("recorded_value: expected %0d, actual %0d",
                 $signed(want.rec), $signed(m_tdata[15:0]));
          mismatches++;
        end
        if (m_tdata[31:16] !== want.ovl) begin
          $error("overlay_value: expected %0d, actual %0d",
                 $signed(want.ovl), $signed(m_tdata[31:16]));
          mismatches++;
        end
        if (m_tdata[41:32] !== want.pos) begin
          $error("position: expected %0d, actual %0d", want.pos, m_tdata[41:32]);
          mismatches++;
        end
      end
    end
  end

  // Update the bench stores for one accepted beat; ticks queue their read.
  task automatic predict_op(input op_t op, input logic [15:0] ph,
                            input logic [15:0] smp, input logic wr);
    logic [POS_OUT_W-1:0] at;
    playhead_read_t       rd;
    int                   d, q, n, s, k;
    logic [SAMPLE_W-1:0]  v;
    case (op)
      OP_CLEAR: begin
        foreach (rec_mem[i]) rec_mem[i] = '0;
      end
      OP_BAKE: begin
        foreach (rec_mem[i]) rec_mem[i] = ovl_mem[i];
      end
      OP_REBUILD: begin
        d = (div_reg == 0) ? int'(DIV_MIN) : (div_reg > DIV_MAX) ? int'(DIV_MAX) : div_reg;
        q = DEPTH / d;
        n = (DEPTH + d - 1) / d;
        if (q == 0) q = 1;
        // later starts overwrite what earlier segments spilled over
        for (s = 0; s < DEPTH - 1; s += q) begin
          v = rec_mem[s];
          for (k = 0; k < n; k++) begin
            if (s + k < DEPTH) ovl_mem[s + k] = v;
          end
        end
      end
      default: begin
        at = POS_OUT_W'((int'(ph) * DEPTH) >> 16);
        if (wr_gate && wr) rec_mem[at] = smp;
        rd.rec = rec_mem[at];
        rd.ovl = ovl_mem[at];
        rd.pos = at;
        readout_q.push_back(rd);
      end
    endcase
  endtask

  // Present one beat, after a random gap if src_idle_on, and hold it until taken.
  task automatic push_beat(input op_t op, input logic [15:0] ph,
                           input logic [15:0] smp, input logic wr);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {7'd0, wr, smp, ph};
    do @(posedge clk); while (!s_tready);
    predict_op(op, ph, smp, wr);
  endtask

  // Drop valid, let all reads come back, then let a bulk sweep finish.
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (BULK_DRAIN) @(posedge clk);
  endtask

  task automatic set_config(input logic we, input logic [DIV_W-1:0] dv);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WRITE_ENABLE;
    cfg_data  <= CFG_W'(we);
    @(posedge clk);
    cfg_index <= REG_DIVIDE;
    cfg_data  <= dv;
    @(posedge clk);
    cfg_we    <= 1'b0;
    wr_gate = we;
    div_reg = dv;
  endtask

  task automatic test_tick_extremes();
    push_beat(OP_TICK, 16'h0000, 16'h7FFF, 1'b1);
    push_beat(OP_TICK, 16'hFFFF, 16'h8000, 1'b1);
    push_beat(OP_TICK, 16'h003F, 16'h1234, 1'b0);
    push_beat(OP_TICK, 16'h5555, 16'hAAAA, 1'b1);
    push_beat(OP_TICK, 16'hAAAA, 16'h5555, 1'b1);
  endtask

  task automatic test_write_gate();
    quiesce();
    set_config(1'b0, DIV_MIN);
    push_beat(OP_TICK, 16'h0040, 16'hFFFF, 1'b1);
    push_beat(OP_TICK, 16'hFFC0, 16'h0001, 1'b1);
    quiesce();
    set_config(1'b1, DIV_MIN);
  endtask

  task automatic test_bulk_ops();
    push_beat(OP_REBUILD, 16'hFFFF, 16'hFFFF, 1'b1);
    push_beat(OP_TICK, 16'hFFFF, 16'h0000, 1'b0);
    push_beat(OP_TICK, 16'h8000, 16'h0007, 1'b1);
    push_beat(OP_BAKE, 16'h0000, 16'h0000, 1'b0);
    push_beat(OP_TICK, 16'h8000, 16'h0000, 1'b0);
    push_beat(OP_CLEAR, 16'h1234, 16'h4321, 1'b1);
    push_beat(OP_TICK, 16'h0000, 16'h0000, 1'b0);
    push_beat(OP_TICK, 16'hFFFF, 16'h0000, 1'b0);
  endtask

  // divide at the top, zero (taken as one) and above the top (saturated)
  task automatic test_divide_limits();
    logic [DIV_W-1:0] dv [3];
    dv = '{DIV_MAX, 8'd0, 8'd255};
    foreach (dv[i]) begin
      quiesce();
      set_config(1'b1, dv[i]);
      push_beat(OP_TICK, {10'd1016, 6'($urandom)}, 16'($urandom), 1'b1);
      push_beat(OP_REBUILD, 16'h0000, 16'h0000, 1'b0);
      push_beat(OP_TICK, {10'd1023, 6'($urandom)}, 16'h0000, 1'b0);
      push_beat(OP_TICK, {10'd1020, 6'($urandom)}, 16'h0000, 1'b0);
    end
  endtask

  task automatic test_random_mix();
    logic                 we;
    logic [DIV_W-1:0]     dv;
    logic [POS_OUT_W-1:0] at;
    int                   r;
    for (int seg = 0; seg < 8; seg++) begin
      case (seg)
        0: begin we = 1'b1; dv = DIV_MIN; end
        1: begin we = 1'b1; dv = DIV_MAX; end
        2: begin we = 1'b0; dv = DIV_W'($urandom_range(2, 127)); end
        3: begin we = 1'b1; dv = DIV_W'($urandom_range(129, 255)); end
        default: begin
          we = ($urandom_range(0, 5) != 0);
          dv = DIV_W'($urandom_range(0, 255));
        end
      endcase
      // one segment runs back to back on both sides
      src_idle_on  = (seg != 4);
      sink_idle_on = (seg != 4);
      quiesce();
      set_config(we, dv);
      for (int i = 0; i < 50; i++) begin
        r = $urandom_range(0, 99);
        if (r < 88) begin
          // revisit a few positions so reads see earlier writes and segments
          if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 7))
              0: at = 10'd0;
              1: at = 10'd1;
              2: at = 10'd8;
              3: at = 10'd9;
              4: at = 10'd512;
              5: at = 10'd1016;
              6: at = 10'd1022;
              default: at = 10'd1023;
            endcase
          end else begin
            at = POS_OUT_W'($urandom);
          end
          push_beat(OP_TICK, {at, 6'($urandom)}, 16'($urandom),
                    $urandom_range(0, 9) < 6);
        end else if (r < 91) begin
          push_beat(OP_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom));
        end else if (r < 94) begin
          push_beat(OP_BAKE, 16'($urandom), 16'($urandom), 1'($urandom));
        end else begin
          push_beat(OP_REBUILD, 16'($urandom), 16'($urandom), 1'($urandom));
        end
      end
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= OP_TICK;
    cfg_we    <= 1'b0;
    cfg_index <= REG_WRITE_ENABLE;
    cfg_data  <= '0;
    foreach (rec_mem[i]) begin
      rec_mem[i] = '0;
      ovl_mem[i] = '0;
    end
    wr_gate = 1'b1;
    div_reg = DIV_MIN;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_config(1'b1, DIV_MIN);
    test_tick_extremes();
    test_write_gate();
    test_bulk_ops();
    test_divide_limits();
    test_random_mix();
    quiesce();

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
